// ----- rtl/core/gmps_pkg.sv -----
// shared types, constants and helper functions of the grid max path sum counter
`timescale 1ns / 1ps
`default_nettype none

package gmps_pkg;

	localparam int SUM_W     = 42;
	localparam int OUT_SUM_W = 43;
	localparam int CNT_W     = 63;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(1);

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

	// one row entry: best sum ending at a cell and the number of paths reaching it
	typedef struct packed {
		sum_t sum;
		cnt_t cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// per-cell position flags carried down the pipeline
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
		logic has_left;
		logic has_right;
	} cell_flags_t;

	// saturating add of two path counts
	function automatic cnt_t cnt_add(cnt_t a, cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	// larger sum wins, ties add their counts; a is kept on a strict loss of b
	function automatic entry_t pick_best(entry_t a, entry_t b);
		entry_t r;
		r = a;
		if ($signed(b.sum) > $signed(a.sum)) begin
			r = b;
		end else if (b.sum == a.sum) begin
			r.cnt = cnt_add(a.cnt, b.cnt);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gmps_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module gmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/grid_max_path_sum_counter.sv -----
// top level of the grid maximum path sum and path count engine
`timescale 1ns / 1ps
`default_nettype none

// Streams grid cell weights in row-major order, one word per accepted cell, and
// after the last cell of a grid returns one word: the best top-to-bottom path sum
// (a path may go straight down or diagonally down-left or down-right) and the
// number of paths that reach it, saturating. One ram of MAX_COLS entries holds the
// row above; each cell reads its right upper neighbor when it is accepted and
// overwrites its own column at the write-back stage, while the left and center upper
// neighbors ride in a two-entry window fed from earlier reads. With num_cols of
// five or more the block takes one cell per cycle; for narrower grids a new cell
// is taken only after the previous one has written its column to the ram. The
// result word is built as the last cell leaves the pipeline and sits in an output
// register, so cells keep flowing while it waits; only a second finished grid
// stalls the input. A write to num_cols or num_rows restarts the grid and may be
// issued only while the block is idle. Sums saturate to 42 bits.
module grid_max_path_sum_counter
	import gmps_pkg::*;
#(
	parameter int MAX_COLS    = 1024,
	parameter int MAX_ROWS    = 1024,
	parameter int WEIGHT_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	// cell word in
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [WEIGHT_BITS-1:0] cell_weight,
	// result word out
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [OUT_SUM_W-1:0]        best_sum,
	output logic [CNT_W-1:0]                   path_count
);

	// column index / ram address width and widths able to hold the dimension itself
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CLW = $clog2(MAX_COLS + 1);
	localparam int RLW = $clog2(MAX_ROWS + 1);
	// adder width for row sum plus weight
	localparam int ADD_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;
	// rows this narrow would read a column before the row above has written it
	localparam int NARROW_COLS = 4;

	// configuration and position state
	logic [CLW-1:0] cols_q;
	logic [RLW-1:0] rows_q;
	logic           narrow_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;

	// pipeline stage registers
	logic                          v_s1, v_s2, v_s3, v_s4;
	cell_flags_t                   flags_s1, flags_s2, flags_s3, flags_s4;
	logic [CW-1:0]                 col_s1, col_s2, col_s3;
	logic signed [WEIGHT_BITS-1:0] w_s1, w_s2, w_s3;
	entry_t                        best_s2, right_s2, best_s3, ent_s4;

	// upper-neighbor window and the column-zero entry of the row just finished
	entry_t win_l_q, win_c_q, head_q;

	// running best over the bottom row
	entry_t run_q;

	// result word register
	logic   out_valid_q;
	entry_t out_q;

	logic                   advance;
	logic                   in_fire;
	logic                   cfg_hit;
	logic [31:0]            cfg_d32;
	logic [CLW-1:0]         cols_clamped;
	logic [RLW-1:0]         rows_clamped;
	cell_flags_t            flags_s0;
	logic [CW-1:0]          rd_addr;
	logic [ENTRY_W-1:0]     ram_rdata;
	entry_t                 rd_entry;
	entry_t                 cur_c;
	entry_t                 pair_lc;
	entry_t                 comb_s2;
	logic [ADD_W-1:0]       add_a, add_b, add_sum;
	entry_t                 new_ent;
	entry_t                 run_nxt;
	logic                   grid_done_s4;

	// ---------------------------------------------------------------------
	// handshake and flow control
	// ---------------------------------------------------------------------

	// a finished grid at the last stage with the output register still full and not taken freezes all
	assign grid_done_s4 = v_s4 && flags_s4.last_row && flags_s4.last_col;
	assign advance      = !(grid_done_s4 && out_valid_q && !out_ready);

	// narrow rows interlock: the previous cell must have written the ram first
	assign in_ready = advance && (!narrow_q || !(v_s1 || v_s2 || v_s3));
	assign in_fire  = in_valid && in_ready;

	// ---------------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------------

	assign cfg_hit = cfg_we && ((cfg_index == REG_NUM_COLS) || (cfg_index == REG_NUM_ROWS));
	assign cfg_d32 = 32'(cfg_data);

	// zero counts as one, anything above the maximum counts as the maximum
	always_comb begin
		if (cfg_data == '0) begin
			cols_clamped = CLW'(1);
			rows_clamped = RLW'(1);
		end else begin
			cols_clamped = (cfg_d32 > 32'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(cfg_d32);
			rows_clamped = (cfg_d32 > 32'(MAX_ROWS)) ? RLW'(MAX_ROWS) : RLW'(cfg_d32);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= CLW'(1);
			rows_q   <= RLW'(1);
			narrow_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_NUM_COLS) begin
				cols_q   <= cols_clamped;
				narrow_q <= (32'(cols_clamped) <= 32'(NARROW_COLS));
			end else if (cfg_index == REG_NUM_ROWS) begin
				rows_q <= rows_clamped;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 0: position tracking, right-neighbor read
	// ---------------------------------------------------------------------

	always_comb begin
		flags_s0.first_row = (row_q == '0);
		flags_s0.last_row  = ((RLW'(row_q) + RLW'(1)) == rows_q);
		flags_s0.last_col  = ((CLW'(col_q) + CLW'(1)) == cols_q);
		flags_s0.has_left  = (col_q != '0);
		flags_s0.has_right = !flags_s0.last_col;
	end

	// wraps only for the last column, where the data is not used
	assign rd_addr = col_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (flags_s0.last_col) begin
				col_q <= '0;
				row_q <= flags_s0.last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------------------------------------------------------------
	// row memory: entry c holds the row above until the current cell c overwrites it
	// ---------------------------------------------------------------------

	gmps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_COLS)
	) u_row_ram (
		.clk   (clk),
		.we    (v_s3 && advance),
		.waddr (col_s3),
		.wdata (new_ent),
		.re    (advance),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// ---------------------------------------------------------------------
	// stage 1: left against center
	// ---------------------------------------------------------------------

	// a row start takes its center from the saved column-zero entry
	assign cur_c   = flags_s1.has_left ? win_c_q : head_q;
	assign pair_lc = flags_s1.has_left ? pick_best(cur_c, win_l_q) : cur_c;

	// ---------------------------------------------------------------------
	// stage 2: fold in the right neighbor
	// ---------------------------------------------------------------------

	assign comb_s2 = flags_s2.has_right ? pick_best(best_s2, right_s2) : best_s2;

	// ---------------------------------------------------------------------
	// stage 3: add the weight, saturate, write back
	// ---------------------------------------------------------------------

	always_comb begin
		add_a   = flags_s3.first_row ? '0
		        : {{(ADD_W-SUM_W){best_s3.sum[SUM_W-1]}}, best_s3.sum};
		add_b   = {{(ADD_W-WEIGHT_BITS){w_s3[WEIGHT_BITS-1]}}, w_s3};
		add_sum = add_a + add_b;
		// top bits all equal means the sum fits the row sum width
		if ((&add_sum[ADD_W-1:SUM_W-1]) || !(|add_sum[ADD_W-1:SUM_W-1])) begin
			new_ent.sum = add_sum[SUM_W-1:0];
		end else begin
			new_ent.sum = add_sum[ADD_W-1] ? SUM_MIN : SUM_MAX;
		end
		new_ent.cnt = flags_s3.first_row ? CNT_W'(1) : best_s3.cnt;
	end

	// ---------------------------------------------------------------------
	// stage 4: running best over the bottom row
	// ---------------------------------------------------------------------

	assign run_nxt = pick_best(run_q, ent_s4);

	// ---------------------------------------------------------------------
	// pipeline registers
	// ---------------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s1 <= flags_s0;
			col_s1   <= col_q;
			w_s1     <= cell_weight;

			flags_s2 <= flags_s1;
			col_s2   <= col_s1;
			w_s2     <= w_s1;
			best_s2  <= pair_lc;
			right_s2 <= rd_entry;

			flags_s3 <= flags_s2;
			col_s3   <= col_s2;
			w_s3     <= w_s2;
			best_s3  <= comb_s2;

			flags_s4 <= flags_s3;
			ent_s4   <= new_ent;

			// slide the upper-neighbor window along the row
			if (v_s1) begin
				win_l_q <= cur_c;
				win_c_q <= rd_entry;
			end
			if (v_s3 && !flags_s3.has_left) begin
				head_q <= new_ent;
			end
		end
	end

	// running best and result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q.sum   <= SUM_MIN;
			run_q.cnt   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				run_q.sum <= SUM_MIN;
				run_q.cnt <= '0;
			end else if (advance && v_s4 && flags_s4.last_row) begin
				if (flags_s4.last_col) begin
					run_q.sum <= SUM_MIN;
					run_q.cnt <= '0;
				end else begin
					run_q <= run_nxt;
				end
			end

			if (advance && grid_done_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && grid_done_s4) begin
			out_q <= run_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_sum   = {out_q.sum[SUM_W-1], out_q.sum};
	assign path_count = out_q.cnt;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------

	// narrow rows never overlap two cells in the read-to-write window
	assert property (@(posedge clk) disable iff (!arst_n)
		(narrow_q && (v_s1 || v_s2 || v_s3)) |-> !in_ready)
	else $error("narrow-row interlock let a cell in over an unwritten column");

	// a new result word only follows a finished grid at the last stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(grid_done_s4))
	else $error("result word raised without a finished grid");

	// the column position stays inside the row
	assert property (@(posedge clk) disable iff (!arst_n)
		CLW'(col_q) < cols_q)
	else $error("column position ran past the row");

	// the pipeline freezes only while a result word is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> (out_valid && grid_done_s4))
	else $error("pipeline stalled with no pending result word");

endmodule

`default_nettype wire
